@@ src/bitmap_buddy_block_allocator_top_defines.svh @@
// Assertion macros for the buddy block allocator
`ifndef BITMAP_BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define BBA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked also while reset is asserted
`define BBA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/bba_pkg.sv @@
// ---------------------------------------------------------------------------
// bba_pkg
// Types and constants of the bitmap buddy block allocator.
// ---------------------------------------------------------------------------
`default_nettype none
package bba_pkg;

   localparam int Layers     = 4;
   localparam int TopBlocks  = 64;
   localparam int BigMult    = 1 << (Layers - 1);
   localparam int TreeSize   = TopBlocks * ((1 << Layers) - 1);
   localparam int AddrW      = $clog2(TreeSize);
   localparam int SmallW     = 9;
   localparam int CountW     = 10;
   localparam int TopW       = 7;
   localparam int LayerW     = $clog2(Layers);
   localparam int IdxW       = SmallW + 1;

   localparam logic [2:0] ACT_ALLOC   = 3'd0;
   localparam logic [2:0] ACT_FREE    = 3'd1;
   localparam logic [2:0] ACT_RESERVE = 3'd2;
   localparam logic [2:0] ACT_RELEASE = 3'd3;
   localparam logic [2:0] ACT_QUERY   = 3'd4;

   localparam logic [1:0] ST_FREE     = 2'd0;
   localparam logic [1:0] ST_RESERVED = 2'd1;
   localparam logic [1:0] ST_UNMAPPED = 2'd2;

   typedef struct packed {
      logic [2:0]        action;
      logic [SmallW-1:0] start_block;
      logic [CountW-1:0] block_count;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [SmallW-1:0] base_block;
      logic [1:0]        block_state;
   } rsp_type;

   // memory port command from the sequencer
   typedef struct packed {
      logic             rd;
      logic             wr;
      logic [AddrW-1:0] addr;
      logic             wdata;
   } mem_cmd_type;

   function automatic logic [AddrW-1:0] layer_base(input logic [LayerW-1:0] layer);
      logic [AddrW+Layers-1:0] b;
      b = (AddrW+Layers)'(TopBlocks) * (((AddrW+Layers)'(1) << layer) - 1'b1);
      return b[AddrW-1:0];
   endfunction

endpackage
`default_nettype wire

@@ src/bitmap_buddy_block_allocator_top.sv @@
// ---------------------------------------------------------------------------
// bitmap_buddy_block_allocator_top
// Buddy allocator over a layered bitmap tree held in a single-port memory.
// ---------------------------------------------------------------------------
// channel | ports                           | handshake
// request | req_item                        | start && !busy
// result  | rsp_item                        | rsp_valid, one cycle
// config  | csr_we, csr_wdata               | csr_we
//
// Each item walks the tree one memory access at a time: a query reads one
// leaf bit, a range mark writes each leaf and then reads the two children of
// each parent and writes the parent, and an allocation search reads buddy
// pairs layer by layer up to a top-layer scan. After reset a clearing pass writes
// all 960 tree bits to used; busy stays high meanwhile. Results cannot be stalled.
`default_nettype none
module bitmap_buddy_block_allocator_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire bba_pkg::req_type          req_item,
   output logic                           rsp_valid,
   output bba_pkg::rsp_type               rsp_item,
   input  wire logic                      csr_we,
   input  wire logic [bba_pkg::TopW-1:0]  csr_wdata
);
   import bba_pkg::*;

   logic [TopW-1:0] top_blocks_ff;
   mem_cmd_type     cmd;
   logic            rdata;

   always_ff @(posedge clock) begin
      if (reset) top_blocks_ff <= TopW'(TopBlocks);
      else if (csr_we) top_blocks_ff <= csr_wdata;
   end

   bba_seq u_seq (
      .clock(clock), .reset(reset), .go(start), .req(req_item), .top_cfg(top_blocks_ff),
      .busy(busy), .done(rsp_valid), .rsp(rsp_item), .cmd(cmd), .rdata(rdata)
   );

   bba_tree_ram u_ram (.clock(clock), .cmd(cmd), .rdata(rdata));
endmodule
`default_nettype wire

@@ src/bba_tree_ram.sv @@
// ---------------------------------------------------------------------------
// bba_tree_ram
// Tree bitmap store: one bit per block of every layer, registered read.
// Resets to all used by a clearing pass run from the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
module bba_tree_ram (
   input  wire logic                 clock,
   input  wire bba_pkg::mem_cmd_type cmd,
   output logic                      rdata
);
   import bba_pkg::*;

   logic mem [TreeSize];
   logic rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) mem[cmd.addr] <= cmd.wdata;
      if (cmd.rd) rdata_ff <= mem[cmd.addr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

@@ src/bba_seq.sv @@
// ---------------------------------------------------------------------------
// bba_seq
// Request sequencer: walks the tree one memory access at a time.
// ---------------------------------------------------------------------------
`default_nettype none
module bba_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 go,
   input  wire bba_pkg::req_type     req,
   input  wire logic [bba_pkg::TopW-1:0] top_cfg,
   output logic                      busy,
   output logic                      done,
   output bba_pkg::rsp_type          rsp,
   output bba_pkg::mem_cmd_type      cmd,
   input  wire logic                 rdata
);
   import bba_pkg::*;
`include "bitmap_buddy_block_allocator_top_defines.svh"

   typedef enum logic [11:0] {
      S_CLEAR  = 12'b000000000001,
      S_IDLE   = 12'b000000000010,
      S_DISP   = 12'b000000000100,
      S_FRD    = 12'b000000001000,  // pair search read a
      S_FRB    = 12'b000000010000,  // read b
      S_FCMP   = 12'b000000100000,
      S_TOPRD  = 12'b000001000000,  // top layer scan read
      S_TOPCHK = 12'b000010000000,
      S_MARK   = 12'b000100000000,  // write leaf / alloc bits
      S_PRD    = 12'b001000000000,  // parent child reads
      S_PCMP   = 12'b010000000000,
      S_DONE   = 12'b100000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [AddrW-1:0]  clr_ff, clr_in;
   req_type           req_ff, req_in;
   logic [TopW-1:0]   top_ff, top_in;       // saturated mapped top count
   logic [LayerW-1:0] lay_ff, lay_in;
   logic [LayerW-1:0] want_ff, want_in;
   logic [IdxW-1:0]   i_ff, i_in;           // scan index
   logic [IdxW-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [IdxW-1:0]   mend_ff, mend_in;     // leaf-range end, exclusive
   logic [IdxW-1:0]   run_ff, run_in, rstart_ff, rstart_in;
   logic              a_ff, a_in, sub_ff, sub_in;
   logic              bigrun_ff, bigrun_in; // top run allocation
   logic [1:0]        k_ff, k_in;
   logic [IdxW-1:0]   g_ff, g_in;
   logic              mval_ff, mval_in;     // value marked in range
   // alloc split mark: at layer lay write idx .. span
   logic              amark_ff, amark_in;
   logic [IdxW-1:0]   aidx_ff, aidx_in;
   rsp_type           rsp_ff, rsp_in;
   logic              done_ff, done_in;

   logic [CountW-1:0] cnt_w;
   logic [LayerW-1:0] clog_w;
   logic [IdxW-1:0]   limit_w, grp_w, pidx_w, mcount_w;
   logic [IdxW+1:0]   endsum_w;
   logic [AddrW-1:0]  taddr_w;

   always_comb begin
      clog_w = '0;
      for (int k = Layers - 1; k >= 1; k--)
         if (req_ff.block_count > CountW'(1 << (k - 1))) begin
            clog_w = LayerW'(k);
            break;
         end
   end

   assign limit_w = IdxW'(top_ff) << (Layers - 1);
   assign grp_w   = (IdxW'(top_ff) << lay_ff) >> 3;
   assign pidx_w  = (g_ff << 3) + IdxW'({k_ff, 1'b0});
   assign mcount_w = (req_ff.action == ACT_FREE && req_ff.block_count <= CountW'(BigMult))
                     ? IdxW'(1) << clog_w : IdxW'(req_ff.block_count);
   assign cnt_w   = req_ff.block_count;
   assign endsum_w = (IdxW+2)'(req_ff.start_block) + (IdxW+2)'(mcount_w);

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; req_in = req_ff; top_in = top_ff;
      lay_in = lay_ff; want_in = want_ff; i_in = i_ff; lo_in = lo_ff; hi_in = hi_ff;
      mend_in = mend_ff; run_in = run_ff; rstart_in = rstart_ff; a_in = a_ff;
      sub_in = sub_ff; bigrun_in = bigrun_ff; k_in = k_ff; g_in = g_ff;
      mval_in = mval_ff; amark_in = amark_ff; aidx_in = aidx_ff; rsp_in = rsp_ff;
      done_in = 1'b0;
      cmd = '0;
      taddr_w = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr = 1'b1; cmd.addr = clr_ff; cmd.wdata = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AddrW'(TreeSize - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (go) begin
               req_in = req;
               if (top_cfg == '0) top_in = TopW'(1);
               else if (top_cfg > TopW'(TopBlocks)) top_in = TopW'(TopBlocks);
               else top_in = top_cfg;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            rsp_in = '0; amark_in = 1'b0; bigrun_in = 1'b0;
            state_in = S_DONE;
            case (req_ff.action)
               ACT_QUERY: begin
                  rsp_in.ok = 1'b1;
                  if (IdxW'(req_ff.start_block) >= limit_w)
                     rsp_in.block_state = ST_UNMAPPED;
                  else begin
                     cmd.rd = 1'b1;
                     cmd.addr = layer_base(LayerW'(Layers - 1)) + AddrW'(req_ff.start_block);
                     sub_in = 1'b1; state_in = S_TOPCHK;
                  end
               end
               ACT_FREE, ACT_RESERVE, ACT_RELEASE: begin
                  if (cnt_w != '0) begin
                     rsp_in.ok = 1'b1;
                     mval_in = (req_ff.action == ACT_RESERVE);
                     if (IdxW'(req_ff.start_block) < limit_w) begin
                        mend_in = (endsum_w > (IdxW+2)'(limit_w)) ? limit_w
                                  : IdxW'(endsum_w);
                        i_in = IdxW'(req_ff.start_block);
                        lo_in = IdxW'(req_ff.start_block);
                        lay_in = LayerW'(Layers - 1);
                        state_in = S_MARK;
                     end
                  end
               end
               ACT_ALLOC: begin
                  if (cnt_w != '0) begin
                     if (cnt_w > CountW'(BigMult)) begin
                        bigrun_in = 1'b1; i_in = '0; run_in = '0; rstart_in = '0;
                        state_in = S_TOPRD;
                     end else begin
                        want_in = LayerW'(Layers - 1) - clog_w;
                        lay_in = LayerW'(Layers - 1) - clog_w;
                        g_in = '0; k_in = 2'd3;
                        state_in = (lay_in == '0) ? S_TOPRD : S_FRD;
                        i_in = '0;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_FRD: begin
            if (g_ff >= grp_w) begin
               g_in = '0; k_in = 2'd3;
               lay_in = lay_ff - 1'b1;
               if (lay_ff == LayerW'(1)) begin i_in = '0; state_in = S_TOPRD; end
            end else begin
               cmd.rd = 1'b1; cmd.addr = layer_base(lay_ff) + AddrW'(pidx_w);
               state_in = S_FRB;
            end
         end
         S_FRB: begin
            cmd.rd = 1'b1; cmd.addr = layer_base(lay_ff) + AddrW'(pidx_w + 1'b1);
            state_in = S_FCMP;
         end
         S_FCMP: begin
            if (a_ff != rdata) begin
               aidx_in = a_ff ? pidx_w + 1'b1 : pidx_w;
               amark_in = 1'b1; state_in = S_MARK; i_in = '0;
            end else begin
               state_in = S_FRD;
               k_in = k_ff - 1'b1;
               if (k_ff == 2'd0) g_in = g_ff + 1'b1;
            end
         end
         S_TOPRD: begin
            if (i_ff >= IdxW'(top_ff)) state_in = S_DONE;
            else begin
               cmd.rd = 1'b1; cmd.addr = AddrW'(i_ff); sub_in = 1'b0;
               state_in = S_TOPCHK;
            end
         end
         S_TOPCHK: begin
            if (sub_ff) begin
               // query answer; sub is shared with the parent read pair
               rsp_in.block_state = rdata ? ST_RESERVED : ST_FREE;
               sub_in = 1'b0;
               state_in = S_DONE;
            end else if (bigrun_ff) begin
               state_in = S_TOPRD; i_in = i_ff + 1'b1;
               if (rdata) begin run_in = '0; rstart_in = i_ff + 1'b1; end
               else begin
                  run_in = run_ff + 1'b1;
                  if (((CountW+1)'(run_ff + 1'b1) << (Layers - 1)) >= (CountW+1)'(cnt_w)) begin
                     rsp_in.ok = 1'b1;
                     rsp_in.base_block = SmallW'(rstart_ff << (Layers - 1));
                     mval_in = 1'b1;
                     i_in = rstart_ff << (Layers - 1); lo_in = rstart_ff << (Layers - 1);
                     mend_in = (((IdxW+2)'(rstart_ff) << (Layers - 1)) + (IdxW+2)'(cnt_w)
                                > (IdxW+2)'(limit_w)) ? limit_w
                               : IdxW'((rstart_ff << (Layers - 1)) + IdxW'(cnt_w));
                     lay_in = LayerW'(Layers - 1);
                     state_in = S_MARK;
                  end
               end
            end else begin
               if (!rdata) begin
                  aidx_in = i_ff; lay_in = '0; amark_in = 1'b1; i_in = '0;
                  state_in = S_MARK;
               end else begin i_in = i_ff + 1'b1; state_in = S_TOPRD; end
            end
         end
         S_MARK: begin
            if (amark_ff) begin
               // split path from found layer down to want, then subtree below want
               cmd.wr = 1'b1; cmd.wdata = 1'b1;
               if (lay_ff <= want_ff) begin
                  cmd.addr = layer_base(lay_ff) + AddrW'(aidx_ff);
                  if (lay_ff == want_ff) begin
                     rsp_in.ok = 1'b1;
                     rsp_in.base_block = SmallW'(aidx_ff << (LayerW'(Layers - 1) - want_ff));
                     if (want_ff == LayerW'(Layers - 1)) state_in = S_DONE;
                     else begin
                        lay_in = want_ff + 1'b1; i_in = '0;
                     end
                  end else begin
                     lay_in = lay_ff + 1'b1; aidx_in = aidx_ff << 1;
                  end
               end else begin
                  cmd.addr = layer_base(lay_ff) +
                             AddrW'((aidx_ff << (lay_ff - want_ff)) + i_ff);
                  if (i_ff == (IdxW'(1) << (lay_ff - want_ff)) - 1'b1) begin
                     i_in = '0; lay_in = lay_ff + 1'b1;
                     if (lay_ff == LayerW'(Layers - 1)) state_in = S_DONE;
                  end else i_in = i_ff + 1'b1;
               end
            end else begin
               cmd.wr = 1'b1; cmd.wdata = mval_ff;
               cmd.addr = layer_base(LayerW'(Layers - 1)) + AddrW'(i_ff);
               if (i_ff + 1'b1 == mend_ff) begin
                  hi_in = mend_ff - 1'b1;
                  lo_in = lo_ff >> 1; hi_in = (mend_ff - 1'b1) >> 1;
                  i_in = lo_ff >> 1;
                  lay_in = LayerW'(Layers - 2);
                  state_in = S_PRD;
               end else i_in = i_ff + 1'b1;
            end
         end
         S_PRD: begin
            cmd.rd = 1'b1;
            taddr_w = layer_base(lay_ff + 1'b1) + AddrW'({i_ff, 1'b0});
            cmd.addr = sub_ff ? taddr_w + 1'b1 : taddr_w;
            state_in = sub_ff ? S_PCMP : S_PRD;
            sub_in = ~sub_ff;
         end
         S_PCMP: begin
            cmd.wr = 1'b1; cmd.addr = layer_base(lay_ff) + AddrW'(i_ff);
            cmd.wdata = a_ff | rdata;
            state_in = S_PRD;
            if (i_ff == hi_ff) begin
               if (lay_ff == '0) state_in = S_DONE;
               else begin
                  lay_in = lay_ff - 1'b1; lo_in = lo_ff >> 1; hi_in = hi_ff >> 1;
                  i_in = lo_ff >> 1;
               end
            end else i_in = i_ff + 1'b1;
         end
         S_DONE: begin
            done_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // capture first of a read pair
      if (state_ff == S_FRB || (state_ff == S_PRD && sub_ff)) a_in = rdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; done_ff <= 1'b0; sub_ff <= 1'b0;
         top_ff <= TopW'(TopBlocks);
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; done_ff <= done_in; sub_ff <= sub_in;
         top_ff <= top_in;
      end
      req_ff <= req_in; lay_ff <= lay_in; want_ff <= want_in; i_ff <= i_in;
      lo_ff <= lo_in; hi_ff <= hi_in; mend_ff <= mend_in; run_ff <= run_in;
      rstart_ff <= rstart_in; a_ff <= a_in; bigrun_ff <= bigrun_in; k_ff <= k_in;
      g_ff <= g_in; mval_ff <= mval_in; amark_ff <= amark_in; aidx_ff <= aidx_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign done = done_ff;
   assign rsp  = rsp_ff;

   `BBA_ASSERT(a_done_after_done_state, clock, reset, done_ff |-> $past(state_ff) == S_DONE, "done without done state")
   `BBA_ASSERT(a_no_wr_idle, clock, reset, (state_ff == S_IDLE) |-> !cmd.wr, "write while idle")
   `BBA_ASSERT(a_rdwr_excl, clock, reset, !(cmd.rd && cmd.wr) || state_ff == S_PCMP, "read and write together")
   `BBA_ASSERT_ALWAYS(a_reset_clear, clock, $past(reset) |-> state_ff == S_CLEAR, "reset must start clear")
endmodule
`default_nettype wire
